// File: rtl/neural_activation_and_derivative_assert.svh
// Assertion macros for the activation unit checker.
// Needs nothing else; included by files that hold concurrent assertions.
`ifndef NEURAL_ACTIVATION_AND_DERIVATIVE_ASSERT_SVH
`define NEURAL_ACTIVATION_AND_DERIVATIVE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/nad_pkg.sv
// Shared constants, types and the sigmoid lookup table for the activation unit.
// No dependencies; every other file of the block but the assertion header imports it.
package nad_pkg;

  localparam int unsigned FRAC_BITS     = 12;
  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned LOG2N         = $clog2(TABLE_ENTRIES);

  localparam int unsigned VAL_W  = 16;
  localparam int unsigned TAB_W  = FRAC_BITS + 1;
  localparam int unsigned TIDX_W = LOG2N + 1;
  localparam int unsigned FR_W   = FRAC_BITS + 4;
  localparam int unsigned ARG_W  =
    ((VAL_W + 1 > FRAC_BITS + 4) ? VAL_W + 1 : FRAC_BITS + 4) + 2;
  localparam int unsigned DIF_W  = TAB_W + 1;
  localparam int unsigned IP_W   = DIF_W + FR_W + 1;
  localparam int unsigned OMV_W  =
    ((FRAC_BITS + 2 > VAL_W) ? FRAC_BITS + 2 : VAL_W) + 1;
  localparam int unsigned DP_W   = VAL_W + OMV_W;
  localparam int unsigned DA_W   =
    ((DP_W > 2 * FRAC_BITS + 2) ? DP_W : 2 * FRAC_BITS + 2) + 1;
  localparam int unsigned PRE_W  = DA_W - FRAC_BITS + 1;

  localparam int unsigned SCALE_NUM   = 41;
  localparam int unsigned SCALE_SHIFT = 12;
  localparam int unsigned SC_W        = PRE_W + 7;

  localparam int unsigned NUM_STAGES = 6;
  localparam int unsigned CNT_W      = $clog2(NUM_STAGES + 1);

  typedef longint unsigned u64_t;
  typedef logic [TAB_W-1:0] sig_tab_t [TABLE_ENTRIES+1];

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] vld;
  } pipe_ctrl_t;

  // Product of two Q58 numbers below 2^59, in Q58, from 32-bit halves.
  function automatic u64_t mul58(u64_t a, u64_t b);
    u64_t ah;
    u64_t al;
    u64_t bh;
    u64_t bl;
    u64_t hi;
    u64_t mid;
    u64_t lo;
    ah  = a >> 32;
    al  = a & u64_t'(32'hFFFF_FFFF);
    bh  = b >> 32;
    bl  = b & u64_t'(32'hFFFF_FFFF);
    hi  = ah * bh;
    mid = ah * bl + al * bh;
    lo  = al * bl;
    return (hi << 6) + (mid >> 26) + (lo >> 58);
  endfunction

  // Unsigned quotient by shift and subtract, one bit per step from the top.
  // The divisor stays below 2^63, so the partial remainder never overflows.
  function automatic u64_t udiv64(u64_t dividend, u64_t divisor);
    u64_t quo;
    u64_t rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], dividend[b]};
      if (rem >= divisor) begin
        rem    = rem - divisor;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Rounded sigmoid samples over [-8, 8], evaluated at elaboration.
  function automatic sig_tab_t build_sig_tab();
    sig_tab_t tab;
    u64_t     epow [TABLE_ENTRIES/2+1];
    u64_t     term;
    u64_t     sum;
    u64_t     es;
    u64_t     e;
    u64_t     den;
    u64_t     num;
    u64_t     one38;
    bit       done;
    int       j;
    int       k;
    int       i;
    term  = u64_t'(1) << 58;
    sum   = term;
    done  = 1'b0;
    one38 = u64_t'(1) << 38;
    // exp(-16/N) from its alternating Taylor series.
    for (k = 1; k < 64; k++) begin
      if (!done) begin
        term = udiv64(term * u64_t'(16), u64_t'(TABLE_ENTRIES) * u64_t'(k));
        if (term == u64_t'(0)) begin
          done = 1'b1;
        end else if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    es      = sum;
    epow[0] = u64_t'(1) << 58;
    for (i = 1; i <= TABLE_ENTRIES / 2; i++) begin
      epow[i] = mul58(epow[i-1], es);
    end
    for (i = 0; i <= TABLE_ENTRIES; i++) begin
      j = i - TABLE_ENTRIES / 2;
      if (j < 0) begin
        j = -j;
      end
      e   = epow[j] >> 20;
      den = one38 + e;
      num = (i < TABLE_ENTRIES / 2) ? e : one38;
      tab[i] = TAB_W'(udiv64((num << (FRAC_BITS + 1)) + den, u64_t'(2) * den));
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

// File: rtl/nad_if.sv
// Valid/ready stream interfaces for the activation unit's input and result channels.
// Depends on nad_pkg for the payload widths.
interface nad_in_if import nad_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [VAL_W-1:0] value;
  logic                    last;

  modport source (output valid, output op, output value, output last, input ready);
  modport sink   (input valid, input op, input value, input last, output ready);
endinterface

interface nad_out_if import nad_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result;
  logic                    last_out;

  modport source (output valid, output result, output last_out, input ready);
  modport sink   (input valid, input result, input last_out, output ready);
endinterface

// File: rtl/nad_pipe_ctrl.sv
// Stage valid bits and per-stage load enables for the activation pipeline.
// Depends on nad_pkg for the stage count and the control struct.
module nad_pipe_ctrl import nad_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_ready_i,
  output pipe_ctrl_t ctrl_o
);

  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] vld_d;
  logic [NUM_STAGES-1:0] en;

  // A stage loads when it is empty or its content moves on, so bubbles close up.
  always_comb begin
    en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctrl_o.en  = en;
  assign ctrl_o.vld = vld_q;

endmodule

// File: rtl/nad_sigmoid.sv
// Forward sigmoid path: table index split, table read and interpolation product.
// Depends on nad_pkg for the table, widths and the pipeline control struct.
module nad_sigmoid import nad_pkg::*; (
  input  logic                     clk_i,
  input  pipe_ctrl_t               ctrl_i,
  input  logic signed [VAL_W-1:0]  value_i,
  input  logic                     mode_i,
  output logic        [TAB_W-1:0]  base_o,
  output logic signed [IP_W-1:0]   interp_o
);

  logic signed [ARG_W-1:0]        arg;
  logic signed [ARG_W-1:0]        pos;
  logic [FR_W+LOG2N-1:0]          scaled;
  logic                           lo_sat;
  logic                           hi_sat;

  logic [LOG2N-1:0]               idx_q;
  logic [FR_W-1:0]                fr1_q;
  logic                           lo_q;
  logic                           hi_q;

  logic [TAB_W-1:0]               t0_d;
  logic [TAB_W-1:0]               t1_d;
  logic [TAB_W-1:0]               t0_q;
  logic [TAB_W-1:0]               t1_q;
  logic [FR_W-1:0]                fr2_q;

  logic signed [DIF_W-1:0]        diff;
  logic [TAB_W-1:0]               t0_3_q;
  logic signed [IP_W-1:0]         prod_q;

  // Tanh evaluates the sigmoid at twice the operand.
  always_comb begin
    arg    = mode_i ? (ARG_W'(value_i) <<< 1) : ARG_W'(value_i);
    pos    = arg + $signed(ARG_W'(1) << (FRAC_BITS + 3));
    lo_sat = pos[ARG_W-1];
    hi_sat = !lo_sat && (pos[ARG_W-2:FRAC_BITS+4] != '0);
    scaled = {pos[FRAC_BITS+3:0], LOG2N'(0)};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      idx_q <= scaled[FR_W+LOG2N-1:FR_W];
      fr1_q <= scaled[FR_W-1:0];
      lo_q  <= lo_sat;
      hi_q  <= hi_sat;
    end
  end

  always_comb begin
    if (lo_q) begin
      t0_d = SIG_TAB[TIDX_W'(0)];
    end else if (hi_q) begin
      t0_d = SIG_TAB[TIDX_W'(TABLE_ENTRIES)];
    end else begin
      t0_d = SIG_TAB[TIDX_W'(idx_q)];
    end
    t1_d = SIG_TAB[TIDX_W'(idx_q) + TIDX_W'(1)];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      t0_q  <= t0_d;
      t1_q  <= t1_d;
      fr2_q <= (lo_q || hi_q) ? '0 : fr1_q;
    end
  end

  assign diff = $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      t0_3_q <= t0_q;
      prod_q <= IP_W'(diff) * IP_W'($signed({1'b0, fr2_q}));
    end
  end

  assign base_o   = t0_3_q;
  assign interp_o = prod_q;

endmodule

// File: rtl/nad_deriv.sv
// Derivative path: y*(1-y) for sigmoid or 1-y*y for tanh, rounded to Q format.
// Depends on nad_pkg for widths and the pipeline control struct.
module nad_deriv import nad_pkg::*; (
  input  logic                     clk_i,
  input  pipe_ctrl_t               ctrl_i,
  input  logic signed [VAL_W-1:0]  value_i,
  input  logic                     mode_i,
  output logic signed [PRE_W-1:0]  deriv_o
);

  logic signed [OMV_W-1:0] fac;
  logic signed [DP_W-1:0]  prod_q;
  logic                    mode1_q;
  logic signed [DA_W-1:0]  acc;
  logic signed [DA_W-1:0]  rnd;
  logic signed [PRE_W-1:0] r2_q;
  logic signed [PRE_W-1:0] r3_q;

  assign fac = mode_i ? OMV_W'(value_i)
                      : $signed(OMV_W'(1) << FRAC_BITS) - OMV_W'(value_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      prod_q  <= DP_W'(value_i) * DP_W'(fac);
      mode1_q <= mode_i;
    end
  end

  always_comb begin
    acc = mode1_q ? ($signed(DA_W'(1) << (2 * FRAC_BITS)) - DA_W'(prod_q))
                  : DA_W'(prod_q);
    rnd = (acc + $signed(DA_W'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      r2_q <= PRE_W'(rnd);
    end
    if (ctrl_i.en[3]) begin
      r3_q <= r2_q;
    end
  end

  assign deriv_o = r3_q;

endmodule

// File: rtl/neural_activation_and_derivative.sv
// Top level of the sigmoid / leaky-tanh activation unit with derivative.
// Depends on nad_pkg, nad_if, nad_pipe_ctrl, nad_sigmoid and nad_deriv.
//
//   Channel  Role        Payload                       Handshake
//   in_i     item in     op, value (Q4.12), last       valid/ready
//   out_o    result out  result (Q4.12), last_out      valid/ready
//   cfg      register    cfg_wdata_i = mode            cfg_we_i strobe
//
// One item per cycle while the output is not stalled; each item passes through the
// pipeline stages in order (input stage, index split and multiply, table read
// and round, interpolation multiply, combine, scale and saturate). Reset clears
// all stage valid bits and sets mode to sigmoid. A stalled result holds the
// output stage while earlier stages keep filling empty slots; ready follows
// the output ready through the per-stage enable chain.
module neural_activation_and_derivative import nad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  nad_in_if.sink    in_i,
  nad_out_if.source out_o
);

  typedef struct packed {
    logic op;
    logic mode;
    logic neg;
    logic last;
  } side_t;

  localparam logic signed [SC_W-1:0] SAT_HI = $signed(SC_W'(2 ** (VAL_W - 1) - 1));
  localparam logic signed [SC_W-1:0] SAT_LO = -$signed(SC_W'(2 ** (VAL_W - 1)));

  pipe_ctrl_t              ctrl;
  logic                    mode_q;
  side_t                   side_q [NUM_STAGES];
  logic signed [VAL_W-1:0] val0_q;

  logic        [TAB_W-1:0] base;
  logic signed [IP_W-1:0]  interp;
  logic signed [PRE_W-1:0] deriv;

  logic signed [IP_W-1:0]  step;
  logic signed [PRE_W-1:0] sig;
  logic signed [PRE_W-1:0] fwd;
  logic signed [PRE_W-1:0] pre_d;
  logic signed [PRE_W-1:0] pre_q;
  logic signed [SC_W-1:0]  scl;
  logic signed [VAL_W-1:0] res_d;
  logic signed [VAL_W-1:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  nad_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.en[0]) begin
      val0_q         <= in_i.value;
      side_q[0].op   <= in_i.op;
      side_q[0].mode <= mode_q;
      side_q[0].neg  <= in_i.value[VAL_W-1];
      side_q[0].last <= in_i.last;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (ctrl.en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  nad_sigmoid u_sigmoid (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .value_i  (val0_q),
    .mode_i   (side_q[0].mode),
    .base_o   (base),
    .interp_o (interp)
  );

  nad_deriv u_deriv (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .value_i (val0_q),
    .mode_i  (side_q[0].mode),
    .deriv_o (deriv)
  );

  // Interpolated sigmoid, then 2*s - 1 for tanh.
  always_comb begin
    step  = (interp + $signed(IP_W'(1) << (FRAC_BITS + 3))) >>> (FRAC_BITS + 4);
    sig   = $signed(PRE_W'({1'b0, base})) + PRE_W'(step);
    fwd   = side_q[3].mode ? ((sig <<< 1) - $signed(PRE_W'(1) << FRAC_BITS)) : sig;
    pre_d = side_q[3].op ? deriv : fwd;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[4]) begin
      pre_q <= pre_d;
    end
  end

  // Negative tanh operands, forward or derivative, take the leaky scale.
  always_comb begin
    if (side_q[4].mode && side_q[4].neg) begin
      scl = (SC_W'(pre_q) * $signed(SC_W'(SCALE_NUM))
             + $signed(SC_W'(1) << (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
    end else begin
      scl = SC_W'(pre_q);
    end
    if (scl > SAT_HI) begin
      res_d = VAL_W'(SAT_HI);
    end else if (scl < SAT_LO) begin
      res_d = VAL_W'(SAT_LO);
    end else begin
      res_d = VAL_W'(scl);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[5]) begin
      res_q <= res_d;
    end
  end

  assign in_i.ready     = ctrl.en[0];
  assign out_o.valid    = ctrl.vld[NUM_STAGES-1];
  assign out_o.result   = res_q;
  assign out_o.last_out = side_q[NUM_STAGES-1].last;

endmodule

// File: rtl/nad_checker.sv
// Port-level checker for the activation unit, bound to the top level below.
// Depends on nad_pkg and neural_activation_and_derivative_assert.svh.
`include "neural_activation_and_derivative_assert.svh"

module nad_checker import nad_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [VAL_W-1:0] out_result_i,
  input logic             out_last_i
);

  logic [CNT_W-1:0] cnt_q;
  logic             in_xfer;
  logic             out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Items accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (out_xfer && !in_xfer) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  `NAD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_result_i) && $stable(out_last_i), "stalled result changed")
  `NAD_ASSERT_IMP(a_no_phantom, clk_i, rst_ni, out_valid_i, cnt_q != '0, "result without an accepted item")
  `NAD_ASSERT_IMP(a_depth, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(NUM_STAGES), "more items in flight than stages")
  `NAD_ASSERT_IMP(a_ready_free, clk_i, rst_ni, !out_valid_i, in_ready_i, "input blocked with empty output stage")

endmodule

bind neural_activation_and_derivative nad_checker u_nad_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_result_i (out_o.result),
  .out_last_i   (out_o.last_out)
);
